// File: rtl/fba_pkg.sv
// Package for the fit block allocator: sizes, mode codes, controller states
// and the command and status words between controller and datapath.
// No dependencies.
package fba_pkg;

   // Table geometry.
   localparam int NUM_BLOCKS = 32;
   localparam int SIZE_WIDTH = 16;
   localparam int IDX_W      = $clog2(NUM_BLOCKS);
   localparam int CNT_W      = $clog2(NUM_BLOCKS + 1);

   // Configuration register widths and indexes.
   localparam int MODE_W = 2;
   localparam int CSR_W  = 6;
   localparam logic CSR_FIT_MODE      = 1'b0;
   localparam logic CSR_BLOCKS_IN_USE = 1'b1;

   // Operation codes of a request word.
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_ALLOC = 1'b1;

   // Placement policies.
   localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
   localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } fba_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;    // write a block size and clear its used mark
      logic start;   // latch the file size and clear the search
      logic scan;    // step the table scan
      logic finish;  // mark the chosen block and load the response word
   } fba_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_end;  // all searched blocks read and evaluated
      logic out_free;  // response register can take a word this cycle
   } fba_status_type;

endpackage

// File: rtl/fit_block_allocator.sv
// Top level of the fit block allocator: ties the controller to the datapath.
// Depends on fba_pkg, fba_ctrl and fba_datapath.
//
//   channel  handshake          payload
//   req      req_valid/ready    req_op, req_block_index, req_block_size, req_file_size
//   rsp      rsp_valid/ready    rsp_granted, rsp_chosen_block, rsp_leftover
//   csr      csr_we             csr_index, csr_wdata
//
// A load word passes from idle straight to the finish state, which registers its
// response word; the next request word is taken back in idle.
// An allocate word first scans the active block count (at most 32): the scan reads
// one block size a cycle from the single read port of the size memory, then the
// block evaluates the last read, sees the end of the scan, and in the finish state
// marks the chosen block and registers the response word before it returns to idle.
// Reset clears the used marks, the configuration and all handshake state; sizes
// are undefined until loaded. A stalled response word holds the block in its
// finish step; the next request word is taken once that word is registered.
module fit_block_allocator import fba_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_op,
   input  logic [IDX_W-1:0]      req_block_index,
   input  logic [SIZE_WIDTH-1:0] req_block_size,
   input  logic [SIZE_WIDTH-1:0] req_file_size,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_granted,
   output logic [IDX_W-1:0]      rsp_chosen_block,
   output logic [SIZE_WIDTH-1:0] rsp_leftover,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [CSR_W-1:0]      csr_wdata
);

   fba_cmd_type    cmd;
   fba_status_type status;

   fba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   fba_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_block_index  (req_block_index),
      .req_block_size   (req_block_size),
      .req_file_size    (req_file_size),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_granted      (rsp_granted),
      .rsp_chosen_block (rsp_chosen_block),
      .rsp_leftover     (rsp_leftover)
   );

endmodule

// File: rtl/fba_ctrl.sv
// Controller state machine of the fit block allocator.
// Depends on fba_pkg for the state enum and the command and status structs.
module fba_ctrl import fba_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic           req_op,
   output logic           req_ready,
   input  fba_status_type status,
   output fba_cmd_type    cmd
);

   fba_state_type state_ff;
   fba_state_type state_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_op == OP_ALLOC) ? ST_SCAN : ST_FINISH;
            end
         end
         ST_SCAN: begin
            if (status.scan_end) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Outputs.
   always_comb begin
      req_ready  = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid && (req_op == OP_LOAD);
            cmd.start = req_valid && (req_op == OP_ALLOC);
         end
         ST_SCAN: begin
            cmd.scan = !status.scan_end;
         end
         ST_FINISH: begin
            cmd.finish = status.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // A finished word waits in its state until the response register frees up.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) && !status.out_free |=> (state_ff == ST_FINISH))
      else $error("finish state left while response register was full");

   // An accepted allocate word always starts a scan.
   assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> (state_ff == ST_SCAN))
      else $error("allocate word did not start a scan");

endmodule

// File: rtl/fba_datapath.sv
// Datapath of the fit block allocator: configuration registers, block size
// memory, used marks, scan pipeline, best-candidate registers and response
// register. Depends on fba_pkg.
module fba_datapath import fba_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [CSR_W-1:0]      csr_wdata,
   input  logic [IDX_W-1:0]      req_block_index,
   input  logic [SIZE_WIDTH-1:0] req_block_size,
   input  logic [SIZE_WIDTH-1:0] req_file_size,
   input  fba_cmd_type           cmd,
   output fba_status_type        status,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_granted,
   output logic [IDX_W-1:0]      rsp_chosen_block,
   output logic [SIZE_WIDTH-1:0] rsp_leftover
);

   // Configuration.
   logic [MODE_W-1:0] mode_ff;
   logic [CSR_W-1:0]  bin_ff;
   logic [CNT_W-1:0]  count;

   // Block table.
   logic [SIZE_WIDTH-1:0] size_mem [NUM_BLOCKS];
   logic [NUM_BLOCKS-1:0] used_ff, used_in;

   // Scan and evaluate stages.
   logic [SIZE_WIDTH-1:0] fsize_ff;
   logic [CNT_W-1:0]      scan_idx_ff, scan_idx_in;
   logic                  pipe_v_ff, pipe_v_in;
   logic [IDX_W-1:0]      pipe_idx_ff;
   logic                  pipe_used_ff;
   logic [SIZE_WIDTH-1:0] rd_data_ff;
   logic                  found_ff, found_in;
   logic [IDX_W-1:0]      best_idx_ff, best_idx_in;
   logic [SIZE_WIDTH-1:0] best_left_ff, best_left_in;

   // Response register.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_granted_ff;
   logic [IDX_W-1:0]      rsp_chosen_ff;
   logic [SIZE_WIDTH-1:0] rsp_leftover_ff;

   logic                  issue;
   logic                  fits;
   logic                  take;
   logic [SIZE_WIDTH-1:0] left;
   logic                  load_ok;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_FIRST;
         bin_ff  <= CSR_W'(NUM_BLOCKS);
      end else if (csr_we) begin
         case (csr_index)
            CSR_FIT_MODE:      mode_ff <= csr_wdata[MODE_W-1:0];
            CSR_BLOCKS_IN_USE: bin_ff  <= csr_wdata;
            default:           mode_ff <= mode_ff;
         endcase
      end
   end

   // Search count saturates at the table depth.
   assign count = (bin_ff > CSR_W'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS) : CNT_W'(bin_ff);

   assign load_ok = cmd.load && (CNT_W'(req_block_index) < CNT_W'(NUM_BLOCKS));
   assign issue   = cmd.scan && (scan_idx_ff < count);

   // Block size memory: one write port for loads, one registered read port for scans.
   always_ff @(posedge clock) begin
      if (load_ok) begin
         size_mem[req_block_index] <= req_block_size;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         rd_data_ff <= size_mem[scan_idx_ff[IDX_W-1:0]];
      end
   end

   // Evaluate the block that the memory returned last cycle.
   assign fits = pipe_v_ff && !pipe_used_ff && (rd_data_ff >= fsize_ff);
   assign left = rd_data_ff - fsize_ff;

   always_comb begin
      take = 1'b0;
      if (fits) begin
         if (!found_ff) begin
            take = mode_ff inside {MODE_FIRST, MODE_BEST, MODE_WORST};
         end else begin
            case (mode_ff)
               MODE_BEST:  take = left < best_left_ff;
               MODE_WORST: take = left > best_left_ff;
               default:    take = 1'b0;
            endcase
         end
      end
   end

   // Next values of the scan, candidate, used and response registers.
   always_comb begin
      scan_idx_in  = scan_idx_ff;
      pipe_v_in    = issue;
      found_in     = found_ff;
      best_idx_in  = best_idx_ff;
      best_left_in = best_left_ff;
      used_in      = used_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (cmd.start || cmd.load) begin
         scan_idx_in = '0;
         found_in    = 1'b0;
      end else if (issue) begin
         scan_idx_in = scan_idx_ff + CNT_W'(1);
      end

      if (take) begin
         found_in     = 1'b1;
         best_idx_in  = pipe_idx_ff;
         best_left_in = left;
      end

      if (load_ok) begin
         used_in[req_block_index] = 1'b0;
      end
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         if (found_ff) begin
            used_in[best_idx_ff] = 1'b1;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_idx_ff  <= '0;
         pipe_v_ff    <= 1'b0;
         found_ff     <= 1'b0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         scan_idx_ff  <= scan_idx_in;
         pipe_v_ff    <= pipe_v_in;
         found_ff     <= found_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      best_idx_ff  <= best_idx_in;
      best_left_ff <= best_left_in;
      if (cmd.start) begin
         fsize_ff <= req_file_size;
      end
      if (issue) begin
         pipe_idx_ff  <= scan_idx_ff[IDX_W-1:0];
         pipe_used_ff <= used_ff[scan_idx_ff[IDX_W-1:0]];
      end
      if (cmd.finish) begin
         rsp_granted_ff  <= found_ff;
         rsp_chosen_ff   <= found_ff ? best_idx_ff : '0;
         rsp_leftover_ff <= found_ff ? best_left_ff : '0;
      end
   end

   assign status.scan_end = (scan_idx_ff >= count) && !pipe_v_ff;
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_granted      = rsp_granted_ff;
   assign rsp_chosen_block = rsp_chosen_ff;
   assign rsp_leftover     = rsp_leftover_ff;

   // A refusal or a load word carries zero index and zero leftover.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_granted_ff |-> (rsp_chosen_ff == '0) && (rsp_leftover_ff == '0))
      else $error("non-grant word carries a block index or leftover");

   // A grant marks the chosen block used on the same edge.
   assert property (@(posedge clock) disable iff (reset)
      cmd.finish && found_ff |=> used_ff[$past(best_idx_ff)])
      else $error("granted block was not marked used");

   // Memory data is only evaluated in the cycle after a scan read.
   assert property (@(posedge clock) disable iff (reset)
      pipe_v_ff |-> $past(issue))
      else $error("evaluate stage valid without a read");

endmodule

// File: verif/fit_block_allocator_tb.sv
// Self-checking testbench for fit_block_allocator: a short directed table, then random
// phases under several placement policies and block counts, checked by an in-bench predictor.
// Depends on fba_pkg and the fit_block_allocator RTL.
`timescale 1ns / 1ps

module fit_block_allocator_tb;
   import fba_pkg::*;

   localparam int CYCLE_LIMIT    = 200000;
   localparam int HOLD_CYCLES    = 300;
   localparam int PHASE_WORDS    = 50;
   localparam int NUM_PHASES     = 10;
   localparam int SETTLE_CYCLES  = 40;
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   // One response word as the block reports it.
   typedef struct packed {
      logic                  granted;
      logic [IDX_W-1:0]      block;
      logic [SIZE_WIDTH-1:0] leftover;
   } placement_type;

   typedef enum logic [1:0] {
      ROW_LOAD,
      ROW_ALLOC,
      ROW_CONFIG
   } row_kind_type;

   // Directed row: a load uses arg_a as index and arg_b as size, an allocate uses
   // arg_b as file size, a configuration row uses arg_a as mode and arg_b as count.
   typedef struct packed {
      row_kind_type  kind;
      logic [5:0]    arg_a;
      logic [15:0]   arg_b;
      logic          checked;
      placement_type want;
   } dir_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic                  req_op;
   logic [IDX_W-1:0]      req_block_index;
   logic [SIZE_WIDTH-1:0] req_block_size;
   logic [SIZE_WIDTH-1:0] req_file_size;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic                  rsp_granted;
   logic [IDX_W-1:0]      rsp_chosen_block;
   logic [SIZE_WIDTH-1:0] rsp_leftover;
   logic                  csr_we;
   logic                  csr_index;
   logic [CSR_W-1:0]      csr_wdata;

   // Predictor state: the table, used marks, which entries were ever loaded,
   // and the two configuration registers.
   logic [SIZE_WIDTH-1:0] table_sizes [NUM_BLOCKS];
   logic                  table_used [NUM_BLOCKS];
   logic                  table_loaded [NUM_BLOCKS];
   logic [MODE_W-1:0]     cfg_mode;
   logic [CSR_W-1:0]      cfg_count;

   placement_type pending_placements [$];
   dir_row_type   directed_rows [$];
   int            mismatches;
   int            cycle_count;
   logic          idle_on;
   logic          hold_req;
   logic          hold_active;

   fit_block_allocator dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_block_index  (req_block_index),
      .req_block_size   (req_block_size),
      .req_file_size    (req_file_size),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_granted      (rsp_granted),
      .rsp_chosen_block (rsp_chosen_block),
      .rsp_leftover     (rsp_leftover),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("fit_block_allocator verification failed");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatches = mismatches + 1;
      $display("MISMATCH at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
   endtask

   // Number of blocks a search covers, after saturation.
   function automatic int search_limit();
      return (cfg_count > NUM_BLOCKS) ? NUM_BLOCKS : int'(cfg_count);
   endfunction

   // Applies one accepted word to the predictor and returns the response it causes.
   function automatic placement_type predict_placement(input logic op,
                                                       input logic [IDX_W-1:0] idx,
                                                       input logic [SIZE_WIDTH-1:0] bsize,
                                                       input logic [SIZE_WIDTH-1:0] fsize);
      placement_type res;
      logic [SIZE_WIDTH-1:0] spare;
      int lim;
      res = '0;
      if (op == OP_LOAD) begin
         table_sizes[idx]  = bsize;
         table_used[idx]   = 1'b0;
         table_loaded[idx] = 1'b1;
         return res;
      end
      lim = search_limit();
      if (cfg_mode <= MODE_WORST) begin
         for (int k = 0; k < lim; k++) begin
            if (!table_used[k] && table_sizes[k] >= fsize) begin
               spare = table_sizes[k] - fsize;
               if (!res.granted) begin
                  res.granted  = 1'b1;
                  res.block    = k[IDX_W-1:0];
                  res.leftover = spare;
                  if (cfg_mode == MODE_FIRST) break;
               end else if (cfg_mode == MODE_BEST && spare < res.leftover) begin
                  res.block    = k[IDX_W-1:0];
                  res.leftover = spare;
               end else if (cfg_mode == MODE_WORST && spare > res.leftover) begin
                  res.block    = k[IDX_W-1:0];
                  res.leftover = spare;
               end
            end
         end
      end
      if (res.granted) table_used[res.block] = 1'b1;
      return res;
   endfunction

   // Offers one request word after a random gap when idling is on, and logs its expected response at acceptance.
   task automatic send_word(input logic op, input logic [IDX_W-1:0] idx,
                            input logic [SIZE_WIDTH-1:0] bsize,
                            input logic [SIZE_WIDTH-1:0] fsize,
                            input logic use_typed, input placement_type typed);
      int gap;
      placement_type res;
      gap = idle_on ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_op          <= op;
      req_block_index <= idx;
      req_block_size  <= bsize;
      req_file_size   <= fsize;
      req_valid       <= 1'b1;
      do @(posedge clock); while (!req_ready);
      res = predict_placement(op, idx, bsize, fsize);
      pending_placements.push_back(use_typed ? typed : res);
   endtask

   // Stops offering and waits until every expected response has come back.
   task automatic drain_responses();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_placements.size() != 0);
   endtask

   // Writes the mode register, then the block count register; the block is idle here.
   task automatic set_config(input logic [MODE_W-1:0] mode, input logic [CSR_W-1:0] count);
      csr_we    <= 1'b1;
      csr_index <= CSR_FIT_MODE;
      csr_wdata <= CSR_W'(mode);
      @(posedge clock);
      csr_index <= CSR_BLOCKS_IN_USE;
      csr_wdata <= count;
      @(posedge clock);
      csr_we   <= 1'b0;
      cfg_mode  = mode;
      cfg_count = count;
   endtask

   function automatic void add_row(input row_kind_type kind, input int a, input int b,
                                   input int checked, input int g, input int blk,
                                   input int spare);
      dir_row_type r;
      r.kind          = kind;
      r.arg_a         = a[5:0];
      r.arg_b         = b[15:0];
      r.checked       = (checked != 0);
      r.want.granted  = (g != 0);
      r.want.block    = blk[IDX_W-1:0];
      r.want.leftover = spare[SIZE_WIDTH-1:0];
      directed_rows.push_back(r);
   endfunction

   // Random request word. Allocates are well formed most of the time: file sizes near
   // the stored sizes, exact fits and extremes. An allocate that would search a block
   // never loaded turns into a load of that block instead.
   task automatic make_random_word(output logic op, output logic [IDX_W-1:0] idx,
                                   output logic [SIZE_WIDTH-1:0] bsize,
                                   output logic [SIZE_WIDTH-1:0] fsize);
      int lim;
      int sel;
      int unloaded;
      lim      = search_limit();
      unloaded = -1;
      op       = ($urandom_range(0, 9) < 4) ? OP_LOAD : OP_ALLOC;
      if (lim > 0 && $urandom_range(0, 3) != 0)
         idx = IDX_W'($urandom_range(0, lim - 1));
      else
         idx = IDX_W'($urandom_range(0, NUM_BLOCKS - 1));
      sel = $urandom_range(0, 3);
      case (sel)
         0: bsize = SIZE_WIDTH'($urandom_range(0, 65535));
         1: bsize = $urandom_range(0, 1) ? '1 : '0;
         default: bsize = SIZE_WIDTH'($urandom_range(0, 1000));
      endcase
      sel = $urandom_range(0, 19);
      if (sel < 10)
         fsize = SIZE_WIDTH'($urandom_range(0, 1000));
      else if (sel < 14)
         fsize = SIZE_WIDTH'($urandom_range(0, 65535));
      else if (sel < 17 && lim > 0)
         fsize = table_sizes[$urandom_range(0, lim - 1)];
      else
         fsize = $urandom_range(0, 1) ? '1 : '0;
      for (int k = lim - 1; k >= 0; k--)
         if (!table_loaded[k]) unloaded = k;
      if (op == OP_ALLOC && unloaded >= 0) begin
         op  = OP_LOAD;
         idx = IDX_W'(unloaded);
      end
   endtask

   // Long receiver hold-off, timed in its own process.
   initial begin
      hold_active = 1'b0;
      forever begin
         wait (hold_req);
         hold_req    = 1'b0;
         hold_active = 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         hold_active = 1'b0;
      end
   end

   // Response side: random stalls, then each accepted word is checked against the oldest
   // expectation.
   initial begin
      placement_type want;
      int stall;
      rsp_ready = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         stall = idle_on ? $urandom_range(0, 5) : 0;
         if (stall > 0 || hold_active) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
            while (hold_active) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         if (pending_placements.size() == 0) begin
            report_mismatch("response word with nothing pending", 32'(rsp_granted), 32'd0);
         end else begin
            want = pending_placements.pop_front();
            if (rsp_granted !== want.granted)
               report_mismatch("granted", 32'(rsp_granted), 32'(want.granted));
            if (rsp_chosen_block !== want.block)
               report_mismatch("chosen_block", 32'(rsp_chosen_block), 32'(want.block));
            if (rsp_leftover !== want.leftover)
               report_mismatch("leftover", 32'(rsp_leftover), 32'(want.leftover));
         end
      end
   end

   // Stimulus: reset, directed table, random phases, then the verdict.
   initial begin
      logic op;
      logic [IDX_W-1:0] idx;
      logic [SIZE_WIDTH-1:0] bsize;
      logic [SIZE_WIDTH-1:0] fsize;
      logic [MODE_W-1:0] mode;
      logic [CSR_W-1:0] count;
      dir_row_type r;

      reset           = 1'b1;
      req_valid       = 1'b0;
      req_op          = OP_LOAD;
      req_block_index = '0;
      req_block_size  = '0;
      req_file_size   = '0;
      csr_we          = 1'b0;
      csr_index       = CSR_FIT_MODE;
      csr_wdata       = '0;
      mismatches      = 0;
      cycle_count     = 0;
      idle_on         = 1'b1;
      hold_req        = 1'b0;
      cfg_mode        = MODE_FIRST;
      cfg_count       = CSR_W'(NUM_BLOCKS);
      for (int k = 0; k < NUM_BLOCKS; k++) begin
         table_sizes[k]  = '0;
         table_used[k]   = 1'b0;
         table_loaded[k] = 1'b0;
      end

      //       kind        a                  b      chk  g  blk  leftover
      add_row(ROW_CONFIG, int'(MODE_FIRST),  4,     0,   0, 0,   0);
      add_row(ROW_LOAD,   0,                 100,   1,   0, 0,   0);
      add_row(ROW_LOAD,   1,                 50,    1,   0, 0,   0);
      add_row(ROW_LOAD,   2,                 200,   1,   0, 0,   0);
      add_row(ROW_LOAD,   3,                 50,    1,   0, 0,   0);
      add_row(ROW_ALLOC,  0,                 60,    1,   1, 0,   40);
      add_row(ROW_ALLOC,  0,                 0,     1,   1, 1,   50);
      add_row(ROW_ALLOC,  0,                 65535, 1,   0, 0,   0);
      add_row(ROW_CONFIG, int'(MODE_BEST),   4,     0,   0, 0,   0);
      add_row(ROW_LOAD,   1,                 50,    1,   0, 0,   0);
      add_row(ROW_ALLOC,  0,                 40,    1,   1, 1,   10);
      add_row(ROW_ALLOC,  0,                 50,    1,   1, 3,   0);
      add_row(ROW_CONFIG, int'(MODE_WORST),  4,     0,   0, 0,   0);
      add_row(ROW_LOAD,   0,                 65535, 1,   0, 0,   0);
      add_row(ROW_LOAD,   3,                 65535, 1,   0, 0,   0);
      add_row(ROW_ALLOC,  0,                 0,     1,   1, 0,   65535);
      add_row(ROW_ALLOC,  0,                 200,   1,   1, 3,   65335);
      add_row(ROW_ALLOC,  0,                 200,   1,   1, 2,   0);
      add_row(ROW_ALLOC,  0,                 1,     1,   0, 0,   0);
      add_row(ROW_LOAD,   2,                 7,     1,   0, 0,   0);
      add_row(ROW_CONFIG, int'(MODE_UNUSED), 4,     0,   0, 0,   0);
      add_row(ROW_ALLOC,  0,                 0,     1,   0, 0,   0);
      add_row(ROW_CONFIG, int'(MODE_FIRST),  0,     0,   0, 0,   0);
      add_row(ROW_ALLOC,  0,                 0,     1,   0, 0,   0);
      add_row(ROW_CONFIG, int'(MODE_BEST),   1,     0,   0, 0,   0);
      add_row(ROW_ALLOC,  0,                 65535, 0,   0, 0,   0);
      add_row(ROW_ALLOC,  0,                 0,     0,   0, 0,   0);

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part.
      foreach (directed_rows[i]) begin
         r = directed_rows[i];
         case (r.kind)
            ROW_CONFIG: begin
               drain_responses();
               set_config(r.arg_a[MODE_W-1:0], r.arg_b[CSR_W-1:0]);
            end
            ROW_LOAD:
               send_word(OP_LOAD, r.arg_a[IDX_W-1:0], r.arg_b, SIZE_WIDTH'($urandom),
                         r.checked, r.want);
            default:
               send_word(OP_ALLOC, IDX_W'($urandom), SIZE_WIDTH'($urandom), r.arg_b,
                         r.checked, r.want);
         endcase
      end
      drain_responses();

      // Random phases, each under its own policy and block count.
      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0: begin mode = MODE_FIRST;  count = CSR_W'(NUM_BLOCKS); end
            1: begin mode = MODE_BEST;   count = '1; end
            2: begin mode = MODE_WORST;  count = 6'd1; end
            3: begin mode = MODE_BEST;   count = CSR_W'($urandom_range(2, 32)); end
            4: begin mode = MODE_FIRST;  count = CSR_W'($urandom_range(33, 63)); end
            5: begin mode = MODE_WORST;  count = CSR_W'(NUM_BLOCKS); end
            6: begin mode = MODE_BEST;   count = '0; end
            7: begin mode = MODE_UNUSED; count = CSR_W'($urandom_range(1, 63)); end
            8: begin mode = MODE_WORST;  count = CSR_W'($urandom_range(1, 32)); end
            default: begin mode = MODE_FIRST; count = CSR_W'($urandom_range(1, 32)); end
         endcase
         set_config(mode, count);
         // Phases without any idling on either side.
         idle_on = !(p == 2 || p == 5);
         // Back-pressure: the receiver holds off while the sender keeps offering.
         if (p == 3) hold_req = 1'b1;
         for (int n = 0; n < PHASE_WORDS; n++) begin
            make_random_word(op, idx, bsize, fsize);
            send_word(op, idx, bsize, fsize, 1'b0, '0);
         end
         drain_responses();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("fit_block_allocator verification clean");
      else
         $display("fit_block_allocator verification failed");
      $finish;
   end

endmodule

// File: fit_block_allocator.f
rtl/fba_pkg.sv
rtl/fba_ctrl.sv
rtl/fba_datapath.sv
rtl/fit_block_allocator.sv
verif/fit_block_allocator_tb.sv
